// ----- hdl/hcd_pkg.sv -----
// ----------------------------------------------------------------------------
// hcd_pkg
// shared codes, widths and record types of the hall call dispatcher
// ----------------------------------------------------------------------------
`default_nettype none

package hcd_pkg;

	localparam int FLOORS_DEF    = 16;
	localparam int ELEVATORS_DEF = 8;
	localparam int OWN_W         = 4;   // elevator code incl. "none"
	localparam int RESULT_CAP    = 32;
	localparam int CNT_W         = $clog2(RESULT_CAP + 1);

	// request types
	localparam logic [1:0] REQ_JOB    = 2'd0;
	localparam logic [1:0] REQ_STATUS = 2'd1;
	localparam logic [1:0] REQ_TICK   = 2'd2;
	localparam logic [1:0] REQ_SPARE  = 2'd3;   // ignored

	// button codes
	localparam logic [1:0] BTN_UP    = 2'd0;
	localparam logic [1:0] BTN_DOWN  = 2'd1;
	localparam logic [1:0] BTN_CAB   = 2'd2;
	localparam logic [1:0] BTN_SPARE = 2'd3;    // ignored

	// result kinds
	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_SERVE = 2'd1;
	localparam logic [1:0] KIND_ALERT = 2'd2;

	// configuration register indexes
	localparam logic CFG_LOCAL  = 1'b0;
	localparam logic CFG_MASTER = 1'b1;

	typedef enum logic [1:0] {
		OP_JOB,
		OP_STATUS,
		OP_TICK
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_UP,
		S_DN,
		S_FLUSH
	} state_t;

	// one floor row of the call table
	typedef struct packed {
		logic             up_p;
		logic             dn_p;
		logic [OWN_W-1:0] up_own;
		logic [OWN_W-1:0] dn_own;
	} row_t;

	localparam int ROW_W = $bits(row_t);

	typedef struct packed {
		logic [1:0]       kind;
		logic [3:0]       floor;
		logic [1:0]       button;
		logic [OWN_W-1:0] elev;
	} res_t;

	// commands to the result stage
	typedef struct packed {
		logic push;   // queue a result behind the held one
		logic flush;  // send the held result as the final one
		logic alert;  // send this result at once as the final one
	} out_cmd_t;

endpackage

`default_nettype wire

// ----- hdl/hcd_ram.sv -----
// ----------------------------------------------------------------------------
// hcd_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module hcd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- hdl/hcd_row_update.sv -----
// ----------------------------------------------------------------------------
// hcd_row_update
// modify step of one floor row: job, owner release or dispatch
// ----------------------------------------------------------------------------
`default_nettype none

module hcd_row_update
	import hcd_pkg::*;
#(
	parameter int ELEVATORS = ELEVATORS_DEF
) (
	input  wire op_t              op,
	input  wire row_t             row_in,
	input  wire logic [1:0]       button,
	input  wire logic             finished,
	input  wire logic [OWN_W-1:0] free_elev,
	input  wire logic [2:0]       status_elev,
	input  wire logic [2:0]       local_elev,
	input  wire logic             emit_en,
	output row_t                  row_out,
	output logic                  up_hit,
	output logic                  dn_hit
);

	localparam logic [OWN_W-1:0] NONE = OWN_W'(ELEVATORS);

	always_comb begin
		row_out = row_in;
		unique case (op)
			OP_JOB: begin
				if (button == BTN_UP) begin
					row_out.up_p = !finished;
					if (finished) begin
						row_out.up_own = NONE;
					end
				end else if (button == BTN_DOWN) begin
					row_out.dn_p = !finished;
					if (finished) begin
						row_out.dn_own = NONE;
					end
				end
			end
			OP_STATUS: begin
				if (row_in.up_own == {1'b0, status_elev}) begin
					row_out.up_own = NONE;
				end
				if (row_in.dn_own == {1'b0, status_elev}) begin
					row_out.dn_own = NONE;
				end
			end
			OP_TICK: begin
				if (row_in.up_p && row_in.up_own == NONE) begin
					row_out.up_own = free_elev;
				end
				if (row_in.dn_p && row_in.dn_own == NONE) begin
					row_out.dn_own = free_elev;
				end
			end
			default: begin
				row_out = row_in;
			end
		endcase
	end

	// local jobs after dispatch
	assign up_hit = (op == OP_TICK) && emit_en && row_out.up_p
		&& (row_out.up_own == {1'b0, local_elev});
	assign dn_hit = (op == OP_TICK) && emit_en && row_out.dn_p
		&& (row_out.dn_own == {1'b0, local_elev});

endmodule

`default_nettype wire

// ----- hdl/hcd_out.sv -----
// ----------------------------------------------------------------------------
// hcd_out
// result stage: holds one result back so the final one can be marked
// ----------------------------------------------------------------------------
`default_nettype none

module hcd_out
	import hcd_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire out_cmd_t         cmd,
	input  wire res_t             res,
	output logic                  strobe,
	output logic [1:0]            result_kind,
	output logic [3:0]            result_floor,
	output logic [1:0]            result_button,
	output logic [OWN_W-1:0]      result_elevator,
	output logic                  last
);

	logic strobe_q;
	logic last_q;
	logic held_v_q;
	res_t held_q;
	res_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
			held_v_q <= 1'b0;
		end else begin
			strobe_q <= cmd.alert || ((cmd.push || cmd.flush) && held_v_q);
			if (cmd.push) begin
				held_v_q <= 1'b1;
			end else if (cmd.flush) begin
				held_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.alert) begin
			out_q  <= res;
			last_q <= 1'b1;
		end else if (cmd.push || cmd.flush) begin
			out_q  <= held_q;
			last_q <= cmd.flush;
		end
		if (cmd.push) begin
			held_q <= res;
		end
	end

	assign strobe          = strobe_q;
	assign last            = last_q;
	assign result_kind     = out_q.kind;
	assign result_floor    = out_q.floor;
	assign result_button   = out_q.button;
	assign result_elevator = out_q.elev;

endmodule

`default_nettype wire

// ----- hdl/hall_call_dispatcher.sv -----
// ----------------------------------------------------------------------------
// hall_call_dispatcher
// hall call table with elevator assignment and local job listing
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy stays high
// until the request is fully worked off, so one request is in work at a time.
// The call table lives in a single ram, one row per floor (up/down pending
// and owners), and every change is a read of a row followed in the next
// cycle by its write-back. A job report reads and writes back its row, then
// returns to idle; an alert it raises is registered in the result stage. A
// status update that keeps the elevator available finishes in the accept
// cycle; one that makes it unavailable walks all rows, reading and writing
// back each in turn. A dispatch tick walks all rows, reading each, writing it
// back and then checking its down call, and closes with a flush state, so the
// read-modify-write of one row per floor sets the pace. Results come on the
// result ports for one cycle each, marked by strobe; the receiver cannot
// stall them, and they are spaced as the walk finds them. One result is held
// back until the next is found, so that last can be set on the final one.
// Elevator flags sit in flip-flops and the lowest free elevator is picked
// once per tick. Table rows that were never written read as empty through
// per-row valid bits, so no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module hall_call_dispatcher
	import hcd_pkg::*;
#(
	parameter int FLOORS    = FLOORS_DEF,
	parameter int ELEVATORS = ELEVATORS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	// request channel
	input  wire logic             start,
	output logic                  busy,
	input  wire logic [1:0]       req_type,
	input  wire logic [3:0]       call_floor,
	input  wire logic [1:0]       call_button,
	input  wire logic             call_finished,
	input  wire logic             from_network,
	input  wire logic [2:0]       job_owner,
	input  wire logic [2:0]       status_elevator,
	input  wire logic             status_available,
	input  wire logic             status_idle,
	// configuration channel
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic             cfg_index,
	input  wire logic [2:0]       cfg_data,
	// results
	output logic                  strobe,
	output logic [1:0]            result_kind,
	output logic [3:0]            result_floor,
	output logic [1:0]            result_button,
	output logic [OWN_W-1:0]      result_elevator,
	output logic                  last
);

	localparam int               ADDR_W = $clog2(FLOORS);
	localparam logic [OWN_W-1:0] NONE   = OWN_W'(ELEVATORS);
	localparam logic [ADDR_W-1:0] LAST_ROW = ADDR_W'(FLOORS - 1);
	localparam row_t             EMPTY_ROW = '{up_p: 1'b0, dn_p: 1'b0,
		up_own: NONE, dn_own: NONE};

	// configuration
	logic [2:0] local_q;
	logic       master_q;

	// elevator flags
	logic [ELEVATORS-1:0] avail_q;
	logic [ELEVATORS-1:0] idle_q;
	logic [OWN_W-1:0]     first_free;

	// sequencer
	state_t state_q, state_d;
	op_t    op_q;
	logic [ADDR_W-1:0] addr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              dn_hit_q;
	logic [FLOORS-1:0] row_valid_q;
	logic              rd_valid_s1;

	// latched request fields
	logic [1:0]       btn_q;
	logic             fin_q;
	logic             net_q;
	logic [3:0]       floor_q;
	logic [2:0]       owner_q;
	logic [2:0]       selev_q;
	logic [OWN_W-1:0] free_q;

	// accept decode
	logic       accept;
	logic [5:0] floor_ext;
	logic       job_ok;
	logic       status_ok;
	logic       emit_en;

	// ram and row path
	logic       ram_we;
	logic       ram_re;
	logic [ROW_W-1:0] ram_rdata;
	row_t       row_rd;
	row_t       row_wr;
	logic       up_hit;
	logic       dn_hit;
	logic       cnt_ok;
	logic       last_row;
	logic [4:0] addr_ext;

	out_cmd_t   cmd;
	res_t       res;

	assign cfg_ready = 1'b1;
	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign floor_ext = {2'b00, call_floor};
	assign job_ok    = (call_button != BTN_SPARE) && (floor_ext < 6'(FLOORS));
	assign status_ok = ({1'b0, status_elevator} < OWN_W'(ELEVATORS));
	assign emit_en   = master_q && ({1'b0, local_q} < OWN_W'(ELEVATORS));
	assign cnt_ok    = (cnt_q < CNT_W'(RESULT_CAP));
	assign last_row  = (addr_q == LAST_ROW);
	assign addr_ext  = 5'(addr_q);

	// lowest-numbered elevator that is available and idle
	always_comb begin
		first_free = NONE;
		for (int e = ELEVATORS - 1; e >= 0; e--) begin
			if (avail_q[e] && idle_q[e]) begin
				first_free = OWN_W'(e);
			end
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_q  <= 3'd0;
			master_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_LOCAL:  local_q  <= cfg_data;
				CFG_MASTER: master_q <= cfg_data[0];
				default:    local_q  <= local_q;
			endcase
		end
	end

	// elevator flags are written in the accept cycle of a status update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avail_q <= '0;
			idle_q  <= '0;
		end else if (accept && req_type == REQ_STATUS && status_ok) begin
			for (int e = 0; e < ELEVATORS; e++) begin
				if ({1'b0, status_elevator} == OWN_W'(e)) begin
					avail_q[e] <= status_available;
					idle_q[e]  <= status_idle;
				end
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (req_type)
						REQ_JOB:    state_d = job_ok ? S_RD : S_IDLE;
						REQ_STATUS: state_d = (status_ok && !status_available) ? S_RD : S_IDLE;
						REQ_TICK:   state_d = S_RD;
						default:    state_d = S_IDLE;
					endcase
				end
			end
			S_RD: state_d = S_UP;
			S_UP: begin
				unique case (op_q)
					OP_JOB:    state_d = S_IDLE;
					OP_STATUS: state_d = last_row ? S_IDLE : S_RD;
					OP_TICK:   state_d = S_DN;
					default:   state_d = S_IDLE;
				endcase
			end
			S_DN:    state_d = last_row ? S_FLUSH : S_RD;
			S_FLUSH: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		ram_re    = (state_q == S_RD);
		ram_we    = (state_q == S_UP);
		cmd       = '0;
		res.kind   = KIND_SERVE;
		res.floor  = addr_ext[3:0];
		res.button = BTN_UP;
		res.elev   = {1'b0, local_q};
		unique case (state_q)
			S_UP: begin
				if (op_q == OP_JOB) begin
					cmd.alert  = net_q && fin_q;
					res.kind   = KIND_ALERT;
					res.floor  = floor_q;
					res.button = btn_q;
					res.elev   = (btn_q == BTN_CAB) ? {1'b0, owner_q} : NONE;
				end else begin
					cmd.push = (op_q == OP_TICK) && up_hit && cnt_ok;
				end
			end
			S_DN: begin
				cmd.push   = dn_hit_q && cnt_ok;
				res.button = BTN_DOWN;
			end
			S_FLUSH: cmd.flush = 1'b1;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			row_valid_q <= '0;
		end else begin
			state_q <= state_d;
			if (ram_we) begin
				row_valid_q[addr_q] <= 1'b1;
			end
		end
	end

	// request latch, walk address and result count
	always_ff @(posedge clk) begin
		if (accept) begin
			btn_q   <= call_button;
			fin_q   <= call_finished;
			net_q   <= from_network;
			floor_q <= call_floor;
			owner_q <= job_owner;
			selev_q <= status_elevator;
			free_q  <= first_free;
			cnt_q   <= '0;
			if (req_type == REQ_JOB) begin
				op_q   <= OP_JOB;
				addr_q <= floor_ext[ADDR_W-1:0];
			end else if (req_type == REQ_STATUS) begin
				op_q   <= OP_STATUS;
				addr_q <= '0;
			end else begin
				op_q   <= OP_TICK;
				addr_q <= '0;
			end
		end else begin
			if (cmd.push) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if ((state_q == S_UP && op_q == OP_STATUS && !last_row)
				|| (state_q == S_DN && !last_row)) begin
				addr_q <= addr_q + ADDR_W'(1);
			end
		end
		if (state_q == S_RD) begin
			rd_valid_s1 <= row_valid_q[addr_q];
		end
		if (state_q == S_UP) begin
			dn_hit_q <= dn_hit;
		end
	end

	// rows never written read as empty
	assign row_rd = rd_valid_s1 ? row_t'(ram_rdata) : EMPTY_ROW;

	hcd_ram #(
		.WIDTH (ROW_W),
		.DEPTH (FLOORS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_q),
		.wdata (ROW_W'(row_wr)),
		.re    (ram_re),
		.raddr (addr_q),
		.rdata (ram_rdata)
	);

	hcd_row_update #(
		.ELEVATORS (ELEVATORS)
	) u_update (
		.op          (op_q),
		.row_in      (row_rd),
		.button      (btn_q),
		.finished    (fin_q),
		.free_elev   (free_q),
		.status_elev (selev_q),
		.local_elev  (local_q),
		.emit_en     (emit_en),
		.row_out     (row_wr),
		.up_hit      (up_hit),
		.dn_hit      (dn_hit)
	);

	hcd_out u_out (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.res             (res),
		.strobe          (strobe),
		.result_kind     (result_kind),
		.result_floor    (result_floor),
		.result_button   (result_button),
		.result_elevator (result_elevator),
		.last            (last)
	);

endmodule

`default_nettype wire

// ----- bench/hcd_scoreboard_pkg.sv -----
// ----------------------------------------------------------------------------
// hcd_scoreboard_pkg
// call table predictor and result scoreboard for the hall call dispatcher
// ----------------------------------------------------------------------------
`default_nettype none

package hcd_scoreboard_pkg;

	import hcd_pkg::*;

	localparam int FLOOR_CNT = FLOORS_DEF;
	localparam int NUM_ELEV  = ELEVATORS_DEF;

	localparam logic [OWN_W-1:0] OWNER_NONE = OWN_W'(ELEVATORS_DEF);

	typedef struct packed {
		logic [1:0] req_type;
		logic [3:0] call_floor;
		logic [1:0] call_button;
		logic       call_finished;
		logic       from_network;
		logic [2:0] job_owner;
		logic [2:0] status_elevator;
		logic       status_available;
		logic       status_idle;
	} call_req_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [3:0]       floor;
		logic [1:0]       button;
		logic [OWN_W-1:0] elev;
		logic             last;
	} job_result_t;

	class dispatch_scoreboard;

		bit [2:0]         local_elev;
		bit               master;
		bit               up_pend   [FLOOR_CNT];
		bit               down_pend [FLOOR_CNT];
		bit [OWN_W-1:0]   up_own    [FLOOR_CNT];
		bit [OWN_W-1:0]   down_own  [FLOOR_CNT];
		bit               elev_avail[NUM_ELEV];
		bit               elev_idle [NUM_ELEV];

		job_result_t      expected_jobs[$];
		job_result_t      held;
		bit               have_held;
		int               listed;
		int               errors;
		int               checked;

		function new();
			local_elev = 3'd0;
			master     = 1'b1;
			for (int f = 0; f < FLOOR_CNT; f++) begin
				up_pend[f]   = 1'b0;
				down_pend[f] = 1'b0;
				up_own[f]    = OWNER_NONE;
				down_own[f]  = OWNER_NONE;
			end
			for (int e = 0; e < NUM_ELEV; e++) begin
				elev_avail[e] = 1'b0;
				elev_idle[e]  = 1'b0;
			end
			errors  = 0;
			checked = 0;
		endfunction

		function void write_register(logic idx, logic [2:0] data);
			if (idx == CFG_LOCAL)
				local_elev = data;
			else
				master = data[0];
		endfunction

		function bit [OWN_W-1:0] first_free();
			for (int e = 0; e < NUM_ELEV; e++)
				if (elev_avail[e] && elev_idle[e])
					return OWN_W'(e);
			return OWNER_NONE;
		endfunction

		// one result is held back so the final one can carry last
		function void list_job(int f, logic [1:0] btn);
			if (listed >= RESULT_CAP)
				return;
			if (have_held)
				expected_jobs.push_back(held);
			held      = '{KIND_SERVE, 4'(f), btn, OWN_W'(local_elev), 1'b0};
			have_held = 1'b1;
			listed++;
		endfunction

		function void note_request(call_req_t r);
			case (r.req_type)
				REQ_JOB: begin
					if (r.call_button == BTN_SPARE || int'(r.call_floor) >= FLOOR_CNT)
						return;
					if (r.call_button == BTN_UP) begin
						up_pend[r.call_floor] = !r.call_finished;
						if (r.call_finished)
							up_own[r.call_floor] = OWNER_NONE;
					end else if (r.call_button == BTN_DOWN) begin
						down_pend[r.call_floor] = !r.call_finished;
						if (r.call_finished)
							down_own[r.call_floor] = OWNER_NONE;
					end
					if (r.from_network && r.call_finished)
						expected_jobs.push_back('{KIND_ALERT, r.call_floor, r.call_button,
							(r.call_button == BTN_CAB) ? OWN_W'(r.job_owner) : OWNER_NONE,
							1'b1});
				end
				REQ_STATUS: begin
					if (int'(r.status_elevator) >= NUM_ELEV)
						return;
					elev_avail[r.status_elevator] = r.status_available;
					elev_idle[r.status_elevator]  = r.status_idle;
					if (!r.status_available)
						for (int f = 0; f < FLOOR_CNT; f++) begin
							if (up_own[f] == OWN_W'(r.status_elevator))
								up_own[f] = OWNER_NONE;
							if (down_own[f] == OWN_W'(r.status_elevator))
								down_own[f] = OWNER_NONE;
						end
				end
				REQ_TICK: begin
					for (int f = 0; f < FLOOR_CNT; f++) begin
						if (up_pend[f] && up_own[f] == OWNER_NONE)
							up_own[f] = first_free();
						if (down_pend[f] && down_own[f] == OWNER_NONE)
							down_own[f] = first_free();
					end
					have_held = 1'b0;
					listed    = 0;
					if (master && int'(local_elev) < NUM_ELEV)
						for (int f = 0; f < FLOOR_CNT; f++) begin
							if (up_pend[f] && up_own[f] == OWN_W'(local_elev))
								list_job(f, BTN_UP);
							if (down_pend[f] && down_own[f] == OWN_W'(local_elev))
								list_job(f, BTN_DOWN);
						end
					if (have_held) begin
						held.last = 1'b1;
						expected_jobs.push_back(held);
					end
				end
				default: ;
			endcase
		endfunction

		function void report(string field, logic [3:0] exp_val, logic [3:0] got_val);
			$display("%0t: mismatch on %s: expected %0d, actual %0d",
				$time, field, exp_val, got_val);
			errors++;
		endfunction

		function void check_result(job_result_t got);
			job_result_t exp_res;
			checked++;
			if (expected_jobs.size() == 0) begin
				$display("%0t: unexpected result kind %0d floor %0d button %0d elevator %0d",
					$time, got.kind, got.floor, got.button, got.elev);
				errors++;
				return;
			end
			exp_res = expected_jobs.pop_front();
			if (got.kind !== exp_res.kind)
				report("result_kind", 4'(exp_res.kind), 4'(got.kind));
			if (got.floor !== exp_res.floor)
				report("result_floor", exp_res.floor, got.floor);
			if (got.button !== exp_res.button)
				report("result_button", 4'(exp_res.button), 4'(got.button));
			if (got.elev !== exp_res.elev)
				report("result_elevator", 4'(exp_res.elev), 4'(got.elev));
			if (got.last !== exp_res.last)
				report("last", 4'(exp_res.last), 4'(got.last));
		endfunction

		function int pending_count();
			return expected_jobs.size();
		endfunction

	endclass

endpackage

`default_nettype wire

// ----- bench/tb_hall_call_dispatcher.sv -----
// ----------------------------------------------------------------------------
// tb_hall_call_dispatcher
// self-checking bench for the hall call dispatcher
// ----------------------------------------------------------------------------
// Requests go in through the start/busy handshake with random gaps; every
// accepted request updates a predicted call table, and every strobed result
// is checked against the oldest predicted job. A directed sequence covers
// assignment, release on an unavailable elevator, alerts and ignored codes;
// random phases then run under several local elevator and master settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_hall_call_dispatcher;

	import hcd_pkg::*;
	import hcd_scoreboard_pkg::*;

	localparam int PERIOD      = 20;
	localparam int RESET_LEN   = 7;
	localparam int SETTLE      = 64;    // longest request is a tick
	localparam int STALL_LIMIT = 2000;  // cycles with no handshake at all
	localparam int PHASES      = 6;
	localparam int PHASE_REQS  = 72;

	logic             clk              = 1'b0;
	logic             arst_n           = 1'b0;
	logic             start            = 1'b0;
	logic             busy;
	logic [1:0]       req_type         = '0;
	logic [3:0]       call_floor       = '0;
	logic [1:0]       call_button      = '0;
	logic             call_finished    = 1'b0;
	logic             from_network     = 1'b0;
	logic [2:0]       job_owner        = '0;
	logic [2:0]       status_elevator  = '0;
	logic             status_available = 1'b0;
	logic             status_idle      = 1'b0;
	logic             cfg_valid        = 1'b0;
	logic             cfg_ready;
	logic             cfg_index        = 1'b0;
	logic [2:0]       cfg_data         = '0;
	logic             strobe;
	logic [1:0]       result_kind;
	logic [3:0]       result_floor;
	logic [1:0]       result_button;
	logic [OWN_W-1:0] result_elevator;
	logic             last;

	dispatch_scoreboard sb = new();

	int job_count    = 0;
	int status_count = 0;
	int tick_count   = 0;
	int cfg_count    = 0;
	int stall_cycles = 0;

	always #(PERIOD / 2) clk = ~clk;

	hall_call_dispatcher dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.req_type        (req_type),
		.call_floor      (call_floor),
		.call_button     (call_button),
		.call_finished   (call_finished),
		.from_network    (from_network),
		.job_owner       (job_owner),
		.status_elevator (status_elevator),
		.status_available(status_available),
		.status_idle     (status_idle),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.strobe          (strobe),
		.result_kind     (result_kind),
		.result_floor    (result_floor),
		.result_button   (result_button),
		.result_elevator (result_elevator),
		.last            (last)
	);

	// results cannot be held off, so every strobe is checked at the edge ending it
	always @(posedge clk) begin
		job_result_t got;
		if (arst_n && strobe) begin
			got = '{result_kind, result_floor, result_button, result_elevator, last};
			sb.check_result(got);
		end
	end

	// watchdog: any request, result or register write restarts the count
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe || (cfg_valid && cfg_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no handshake for %0d cycles, %0d jobs still expected",
				$time, STALL_LIMIT, sb.pending_count());
			$display("hall_call_dispatcher verification failed");
			$finish;
		end
	end

	function automatic call_req_t make_req(logic [1:0] kind, logic [3:0] fl, logic [1:0] btn,
			int fin, int net, logic [2:0] own, logic [2:0] elev, int av, int idl);
		return '{kind, fl, btn, 1'(fin), 1'(net), own, elev, 1'(av), 1'(idl)};
	endfunction

	// mostly well-formed requests with random content, some raw noise
	function automatic call_req_t random_request();
		logic [$bits(call_req_t)-1:0] noise;
		call_req_t r;
		int pick;
		noise = $bits(call_req_t)'($urandom);
		r     = noise;
		pick  = $urandom_range(0, 99);
		if (pick < 42) begin
			r.req_type      = REQ_JOB;
			r.call_button   = 2'($urandom_range(0, 2));
			r.call_finished = ($urandom_range(0, 2) == 0);
		end else if (pick < 60) begin
			r.req_type         = REQ_STATUS;
			r.status_available = ($urandom_range(0, 3) != 0);
		end else if (pick < 92) begin
			r.req_type = REQ_TICK;
		end
		return r;
	endfunction

	function automatic bit ignored(call_req_t r);
		return r.req_type == REQ_SPARE || (r.req_type == REQ_JOB && r.call_button == BTN_SPARE);
	endfunction

	// called at a falling edge; start is left high so a back-to-back request
	// follows without a gap, and the caller lowers it before time moves on
	task automatic send_request(call_req_t r, int gap);
		repeat (gap) begin
			start = 1'b0;
			@(negedge clk);
		end
		req_type         = r.req_type;
		call_floor       = r.call_floor;
		call_button      = r.call_button;
		call_finished    = r.call_finished;
		from_network     = r.from_network;
		job_owner        = r.job_owner;
		status_elevator  = r.status_elevator;
		status_available = r.status_available;
		status_idle      = r.status_idle;
		start            = 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_request(r);
		case (r.req_type)
			REQ_JOB:    job_count++;
			REQ_STATUS: status_count++;
			REQ_TICK:   tick_count++;
			default:    ;
		endcase
		@(negedge clk);
	endtask

	// wait until the block is idle and every predicted job has come out
	task automatic drain();
		start = 1'b0;
		@(posedge clk);
		while (busy || sb.pending_count() != 0)
			@(posedge clk);
		repeat (SETTLE)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_register(logic idx, logic [2:0] data);
		start     = 1'b0;
		cfg_index = idx;
		cfg_data  = data;
		cfg_valid = 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.write_register(idx, data);
		cfg_count++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	initial begin
		call_req_t  directed[$];
		call_req_t  r;
		logic [2:0] phase_local [PHASES];
		logic       phase_master[PHASES];
		int         useful;

		// local elevator and master flag per random phase, extremes included
		phase_local  = '{3'd7, 3'd0, 3'd3, 3'($urandom), 3'd0, 3'($urandom)};
		phase_master = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'($urandom)};

		repeat (RESET_LEN)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed part, reset settings: local elevator 0, master
		directed = '{
			make_req(REQ_STATUS, 4'd0,  BTN_UP,   0, 0, 3'd0, 3'd0, 1, 1),  // elevator 0 free
			make_req(REQ_STATUS, 4'd0,  BTN_UP,   0, 0, 3'd0, 3'd7, 1, 1),  // elevator 7 free
			make_req(REQ_JOB,    4'd0,  BTN_UP,   0, 0, 3'd0, 3'd0, 0, 0),
			make_req(REQ_JOB,    4'd15, BTN_DOWN, 0, 0, 3'd0, 3'd0, 0, 0),
			make_req(REQ_JOB,    4'd15, BTN_UP,   0, 1, 3'd7, 3'd0, 0, 0),
			make_req(REQ_JOB,    4'd9,  BTN_CAB,  0, 0, 3'd3, 3'd0, 0, 0),  // cab: no state
			make_req(REQ_TICK,   4'd0,  BTN_UP,   0, 0, 3'd0, 3'd0, 0, 0),  // all to elevator 0
			make_req(REQ_STATUS, 4'd0,  BTN_UP,   0, 0, 3'd0, 3'd0, 0, 1),  // release elevator 0
			make_req(REQ_TICK,   4'd0,  BTN_UP,   0, 0, 3'd0, 3'd0, 0, 0),  // moves to 7, empty
			make_req(REQ_STATUS, 4'd0,  BTN_UP,   0, 0, 3'd0, 3'd7, 1, 0),  // 7 busy, keeps calls
			make_req(REQ_STATUS, 4'd0,  BTN_UP,   0, 0, 3'd0, 3'd0, 1, 1),
			make_req(REQ_JOB,    4'd7,  BTN_UP,   0, 0, 3'd0, 3'd0, 0, 0),
			make_req(REQ_TICK,   4'd0,  BTN_UP,   0, 0, 3'd0, 3'd0, 0, 0),
			make_req(REQ_JOB,    4'd0,  BTN_UP,   1, 1, 3'd5, 3'd0, 0, 0),  // hall alert
			make_req(REQ_JOB,    4'd3,  BTN_CAB,  1, 1, 3'd7, 3'd0, 0, 0),  // cab alert, owner 7
			make_req(REQ_JOB,    4'd15, BTN_DOWN, 1, 1, 3'd0, 3'd0, 0, 0),
			make_req(REQ_JOB,    4'd15, BTN_UP,   1, 0, 3'd0, 3'd0, 0, 0),  // local finish, quiet
			make_req(REQ_JOB,    4'd4,  BTN_SPARE, 0, 1, 3'd2, 3'd0, 0, 0), // bad button
			make_req(REQ_SPARE,  4'd6,  BTN_DOWN, 1, 1, 3'd1, 3'd2, 1, 1),  // bad request type
			make_req(REQ_JOB,    4'd0,  BTN_CAB,  1, 1, 3'd0, 3'd0, 0, 0),  // cab alert, owner 0
			make_req(REQ_JOB,    4'd8,  BTN_DOWN, 0, 1, 3'd4, 3'd0, 0, 0),
			make_req(REQ_TICK,   4'd0,  BTN_UP,   0, 0, 3'd0, 3'd0, 0, 0),
			make_req(REQ_STATUS, 4'd0,  BTN_UP,   0, 0, 3'd0, 3'd5, 0, 1),  // unused, unavailable
			make_req(REQ_TICK,   4'd0,  BTN_UP,   0, 0, 3'd0, 3'd0, 0, 0)
		};
		foreach (directed[i])
			send_request(directed[i], $urandom_range(0, 8));

		// random phases, registers only rewritten once the block has gone quiet
		for (int p = 0; p < PHASES; p++) begin
			drain();
			write_register(CFG_LOCAL, phase_local[p]);
			write_register(CFG_MASTER, {2'($urandom), phase_master[p]});
			useful  = 0;
			while (useful < PHASE_REQS) begin
				r = random_request();
				if (!ignored(r))
					useful++;
				send_request(r, $urandom_range(0, 8));
			end
		end
		drain();

		$display("covered %0d job reports, %0d status updates, %0d ticks, %0d register writes",
			job_count, status_count, tick_count, cfg_count);
		$display("checked %0d results, %0d errors", sb.checked, sb.errors);
		if (sb.errors == 0 && sb.pending_count() == 0)
			$display("hall_call_dispatcher verification clean");
		else
			$display("hall_call_dispatcher verification failed");
		$finish;
	end

endmodule

`default_nettype wire
